FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the base-85 encoder.
// No dependencies; included by the checker module only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define B85_ASSERT(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("b85 assertion failed");

// Clocked assertion that also holds across reset
`define B85_ASSERT_ALWAYS(label, clock, prop) \
  label: assert property (@(posedge clock) prop) \
    else $error("b85 assertion failed");

`endif

FILE: hw/rtl/b85_pkg.sv
// Types and constants of the base-85 string literal encoder.
// Used by the front, queue, back and top-level modules; no dependencies.
package b85_pkg;

  // Command codes on the input tuser
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_TERM = 1'b1;

  // Encoding constants
  localparam int unsigned RADIX      = 85;
  localparam logic [6:0]  BAD_DIGIT  = 7'd52;
  localparam logic [7:0]  DIGIT_BASE = 8'd40;
  localparam logic [7:0]  BAD_CHAR   = 8'd125;   // 40 + 85
  localparam logic [7:0]  CH_QUOTE   = 8'h22;
  localparam logic [7:0]  CH_COMMA   = 8'h2C;
  localparam logic [7:0]  CH_NEWLINE = 8'h0A;

  // Column limit register
  localparam int unsigned    COL_W      = 10;
  localparam logic [COL_W-1:0] COLS_RESET = 10'd128;

  // Reciprocal of 85: q = (w * RECIP_85) >> RECIP_SHIFT for any 32-bit w
  localparam logic [31:0] RECIP_85    = 32'hC0C0C0C1;
  localparam int unsigned RECIP_SHIFT = 38;

  // Digits in a full group
  localparam logic [2:0] FULL_DIGITS = 3'd5;

  // Default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // One job handed from the front to the back
  typedef struct packed {
    logic [31:0] word;    // group bytes, low byte first
    logic [2:0]  ndig;    // digits to write, 0 to 5
    logic        term;    // terminate item: close an open line afterwards
  } b85_job_t;

endpackage

FILE: hw/rtl/b85_front.sv
// Front end: accepts items, gathers bytes into groups and issues jobs.
// Depends on b85_pkg.
module b85_front import b85_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_cmd,
  input  logic [7:0] in_byte,
  output logic     push,
  output b85_job_t push_job,
  input  logic     q_full
);

  logic [31:0] group_word;
  logic [1:0]  byte_count;
  logic [31:0] merged;
  logic        accept;
  logic        is_term;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_term  = (in_cmd == CMD_TERM);

  // New byte dropped into its lane of the group word
  assign merged = group_word | ({24'b0, in_byte} << {byte_count, 3'b000});

  // A job goes out on terminate or when the fourth byte arrives
  assign push = accept && (is_term || byte_count == 2'd3);

  always_comb begin
    push_job.term = is_term;
    if (is_term) begin
      push_job.word = group_word;
      push_job.ndig = (byte_count == 2'd0) ? 3'd0 : ({1'b0, byte_count} + 3'd1);
    end else begin
      push_job.word = merged;
      push_job.ndig = FULL_DIGITS;
    end
  end

  // Group collection
  always_ff @(posedge clk) begin
    if (rst) begin
      group_word <= '0;
      byte_count <= '0;
    end else if (accept) begin
      if (push) begin
        group_word <= '0;
        byte_count <= '0;
      end else begin
        group_word <= merged;
        byte_count <= byte_count + 2'd1;
      end
    end
  end

endmodule

FILE: hw/rtl/b85_queue.sv
// Short job queue between the front and the back end.
// Depends on b85_pkg for the job type.
module b85_queue import b85_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  b85_job_t push_job,
  output logic     full,
  input  logic     pop,
  output b85_job_t head,
  output logic     empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  b85_job_t        entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/b85_back.sv
// Back end: turns jobs into digits and quote framing, taking a new job only once the last one is written.
// Holds the column limit register and the line column. Depends on b85_pkg.
module b85_back import b85_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [COL_W-1:0] cfg_wdata,
  input  b85_job_t         head,
  input  logic             q_empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_char,
  output logic             out_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_REM, S_QUOTE, S_DIGIT, S_CLQ, S_CLC, S_CLN
  } state_t;

  state_t           state;
  logic [COL_W-1:0] max_cols;
  logic [COL_W-1:0] column;
  logic [31:0]      word;
  logic [2:0]       cnt;        // digits left, current one included
  logic             term;
  logic [63:0]      prod;
  logic [7:0]       dchar;

  logic [31:0]      quot;
  logic [31:0]      q_times;
  logic [6:0]       digit;
  logic             slot_free;
  logic             quoting;
  logic [COL_W-1:0] col_inc;
  logic             closes;
  logic             term_close;

  // Quotient from the registered product, remainder by shift-and-add
  assign quot    = 32'(prod[63:RECIP_SHIFT]);
  assign q_times = (quot << 6) + (quot << 4) + (quot << 2) + quot;
  assign digit   = 7'(word - q_times);

  assign slot_free  = !out_valid || out_ready;
  assign quoting    = (max_cols != '0);
  assign col_inc    = column + COL_W'(1);
  assign closes     = quoting && (col_inc == max_cols);
  assign term_close = term && quoting && (col_inc != '0);
  assign pop        = (state == S_IDLE) && !q_empty;

  // Column limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_cols <= COLS_RESET;
    end else if (cfg_wen) begin
      max_cols <= cfg_wdata;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      column    <= '0;
      out_valid <= 1'b0;
      out_char  <= '0;
      out_last  <= 1'b0;
      word      <= '0;
      cnt       <= '0;
      term      <= 1'b0;
      prod      <= '0;
      dchar     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            word <= head.word;
            cnt  <= head.ndig;
            term <= head.term;
            if (head.ndig != 3'd0) begin
              state <= S_MUL;
            end else if (head.term && quoting && column != '0) begin
              column <= '0;
              state  <= S_CLQ;
            end
          end
        end
        S_MUL: begin
          prod  <= {32'b0, word} * {32'b0, RECIP_85};
          state <= S_REM;
        end
        S_REM: begin
          dchar <= (digit == BAD_DIGIT) ? BAD_CHAR : (DIGIT_BASE + {1'b0, digit});
          word  <= quot;
          state <= (quoting && column == '0) ? S_QUOTE : S_DIGIT;
        end
        S_QUOTE: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_char  <= CH_QUOTE;
            out_last  <= 1'b0;
            state     <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_char  <= dchar;
            out_last  <= (cnt == 3'd1) && !closes && !term_close;
            cnt       <= cnt - 3'd1;
            if (closes) begin
              column <= '0;
              state  <= S_CLQ;
            end else begin
              if (quoting) begin
                column <= col_inc;
              end
              if (cnt != 3'd1) begin
                state <= S_MUL;
              end else if (term_close) begin
                column <= '0;
                state  <= S_CLQ;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        S_CLQ: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_char  <= CH_QUOTE;
            out_last  <= 1'b0;
            state     <= S_CLC;
          end
        end
        S_CLC: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_char  <= CH_COMMA;
            out_last  <= 1'b0;
            state     <= S_CLN;
          end
        end
        S_CLN: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_char  <= CH_NEWLINE;
            out_last  <= (cnt == 3'd0);
            state     <= (cnt == 3'd0) ? S_IDLE : S_MUL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/base85_string_literal_encoder.sv
// Top level of the base-85 string literal encoder: front, job queue, back.
// Depends on b85_pkg, b85_front, b85_queue and b85_back.
//
//  channel  | dir | tdata             | tuser     | tlast
//  s_axis   | in  | [7:0] data_byte   | [0] cmd   | -
//  m_axis   | out | [7:0] out_char    | -         | last
//  cfg      | in  | [9:0] max_cols    | -         | -
//
// The front takes one item per cycle while the job queue has room; bytes that
// do not finish a group give no characters.
// The back picks up a job, then per digit runs the reciprocal multiplier and
// the remainder step and writes the digit, with an opening quote before it
// and a closing quote/comma/newline after it as the line needs; all digits
// pass through the single divide-by-85 unit in turn.
// Reset (rst, synchronous) empties the queue, clears group and column and loads
// a column limit of 128. A stalled m_tready holds the back; the front keeps
// accepting until the queue fills.
module base85_string_literal_encoder import b85_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,    // [7:0] data_byte
  input  logic             s_tuser,    // [0] cmd
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,    // [7:0] out_char
  output logic             m_tlast,
  input  logic             cfg_wen,
  input  logic [COL_W-1:0] cfg_wdata
);

  b85_job_t push_job;
  b85_job_t head;
  logic     push;
  logic     q_full;
  logic     q_empty;
  logic     pop;

  b85_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (s_tuser),
    .in_byte  (s_tdata),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  b85_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  b85_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

FILE: hw/rtl/b85_check.sv
// Port-level checker for the base-85 encoder, bound to the top level.
// Depends on assert_macros.svh and b85_pkg.
`include "assert_macros.svh"

module b85_check import b85_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // A stalled character stays put
  `B85_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // Reset leaves nothing on the output
  `B85_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_tvalid)

  // Only digits, quote, comma and newline appear, never a backslash
  `B85_ASSERT(a_no_backslash, clk, rst, m_tvalid |-> m_tdata != 8'h5C && ((m_tdata >= DIGIT_BASE && m_tdata <= BAD_CHAR) || m_tdata == CH_QUOTE || m_tdata == CH_NEWLINE))

  // A quote is never the last character of an item
  `B85_ASSERT(a_quote_not_last, clk, rst, m_tvalid && m_tdata == CH_QUOTE |-> !m_tlast)

endmodule

bind base85_string_literal_encoder b85_check u_b85_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

FILE: bench/base85_string_literal_encoder_tb.sv
// Self-checking testbench for base85_string_literal_encoder: byte and terminate
// items in, encoded characters out, checked against an in-bench encoder model.
// Depends on b85_pkg and the base85_string_literal_encoder RTL only.
`timescale 1ns / 1ps

module base85_string_literal_encoder_tb import b85_pkg::*; ();

  localparam int unsigned LIMIT_CYCLES  = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS   = 40;

  // One expected output character
  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } enc_char_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [7:0]       s_tdata;    // [7:0] data_byte
  logic             s_tuser;    // [0] cmd
  logic             m_tvalid;
  logic             m_tready;
  logic [7:0]       m_tdata;    // [7:0] out_char
  logic             m_tlast;
  logic             cfg_wen;
  logic [COL_W-1:0] cfg_wdata;

  // Encoder model state
  logic [COL_W-1:0] col_limit;
  logic [COL_W-1:0] line_col;
  logic [31:0]      grp_word;
  int unsigned      grp_bytes;
  logic [7:0]       item_chars[$];
  enc_char_t        expected_chars[$];

  // Run control and bookkeeping
  bit          tx_idle;
  bit          rx_idle;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned chars_checked;
  int unsigned limit_writes;

  base85_string_literal_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  // Clock, 2 ns period
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Encoder model
  // ---------------------------------------------------------------------------

  function automatic void close_quoted_line();
    item_chars.push_back(CH_QUOTE);
    item_chars.push_back(CH_COMMA);
    item_chars.push_back(CH_NEWLINE);
    line_col = '0;
  endfunction

  // One base-85 digit of v, with line framing when quoting is on
  function automatic void emit_digit(input logic [31:0] v);
    int unsigned d;
    if (col_limit != 0 && line_col == 0) item_chars.push_back(CH_QUOTE);
    d = v % RADIX;
    if (d == BAD_DIGIT) d = RADIX;   // keeps backslash out of the text
    item_chars.push_back(DIGIT_BASE + 8'(d));
    if (col_limit != 0) begin
      line_col = line_col + 1'b1;    // wraps at 1024
      if (line_col == col_limit) close_quoted_line();
    end
  endfunction

  // n pending bytes give n+1 digits, low digit first
  function automatic void flush_pending_group();
    if (grp_bytes != 0) begin
      while (grp_bytes != 0) begin
        emit_digit(grp_word);
        grp_word = grp_word / RADIX;
        grp_bytes--;
      end
      emit_digit(grp_word);
      grp_word = '0;
    end
  endfunction

  // Characters caused by one accepted item, queued with last marked
  function automatic void predict_encoded_chars(input logic cmd, input logic [7:0] b);
    item_chars.delete();
    if (cmd == CMD_DATA) begin
      grp_word = grp_word | (32'(b) << (8 * grp_bytes));
      grp_bytes++;
      if (grp_bytes == 4) flush_pending_group();
    end else begin
      flush_pending_group();
      if (col_limit != 0 && line_col != 0) close_quoted_line();
    end
    foreach (item_chars[i])
      expected_chars.push_back('{ch: item_chars[i], is_last: (i == item_chars.size() - 1)});
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one item, after a random gap when tx_idle is set; returns once accepted
  task automatic send_item(input logic cmd, input logic [7:0] b);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    predict_encoded_chars(cmd, b);
    items_sent++;
  endtask

  task automatic hold_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Sender stops until every expected character has come out
  task automatic wait_results_done();
    hold_input();
    while (expected_chars.size() != 0) @(negedge clk);
  endtask

  // Column limit write, only with the block idle
  task automatic write_limit(input logic [COL_W-1:0] v);
    wait_results_done();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    col_limit = v;
    limit_writes++;
  endtask

  task automatic send_group(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_item(CMD_DATA, w[8*i +: 8]);
  endtask

  // Output side: random stall before each character when rx_idle is set
  initial begin : rx_stall
    int unsigned stall;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Output check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_output
    enc_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected char: expected none, actual %h last %b",
                 $realtime, m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (m_tdata !== want.ch) begin
          $display("%0t: out_char mismatch: expected %h, actual %h",
                   $realtime, want.ch, m_tdata);
          mismatches++;
        end
        if (m_tlast !== want.is_last) begin
          $display("%0t: last mismatch: expected %b, actual %b",
                   $realtime, want.is_last, m_tlast);
          mismatches++;
        end
        chars_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default limit: extreme bytes, the backslash digit, partial groups, terminates
  task automatic test_default_groups();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_group(32'h0000_0000);
    send_group(32'hFFFF_FFFF);
    send_group(32'h0000_0034);            // low digit is the backslash digit
    send_item(CMD_TERM, 8'hFF);           // byte field ignored, line closed
    send_item(CMD_TERM, 8'h00);           // empty group, no open line
    send_item(CMD_DATA, 8'h54);           // digit 84
    send_item(CMD_TERM, 8'hA5);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'h80);
    send_item(CMD_TERM, 8'h00);
    send_item(CMD_DATA, 8'h01);
    send_item(CMD_DATA, 8'h7F);
    send_item(CMD_DATA, 8'hFE);
    send_item(CMD_TERM, 8'h5A);
  endtask

  // Limit of one digit, the largest limit, and quoting off
  task automatic test_limit_extremes();
    write_limit(10'd1);
    send_group(32'h7856_3412);
    send_item(CMD_DATA, 8'hC3);
    send_item(CMD_TERM, 8'h00);
    write_limit(10'd1023);
    send_group(32'hDEAD_BEEF);
    send_item(CMD_TERM, 8'h00);
    write_limit(10'd0);
    send_group(32'h0102_0304);
    send_item(CMD_DATA, 8'hAA);
    send_item(CMD_DATA, 8'h55);
    send_item(CMD_TERM, 8'hFF);
  endtask

  // Limit lowered below the open column: column runs on past the new limit
  task automatic test_limit_lowered();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    write_limit(10'd16);
    for (int g = 0; g < 2; g++) send_group($urandom);
    write_limit(10'd4);
    for (int g = 0; g < 2; g++) send_group($urandom);
    send_item(CMD_TERM, 8'h00);
  endtask

  // Quoting switched off mid-line, then back on from the same column
  task automatic test_quoting_paused();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    write_limit(10'd8);
    send_group($urandom);
    write_limit(10'd0);
    send_group($urandom);
    send_item(CMD_TERM, 8'h00);           // no closing quote while off
    write_limit(10'd8);
    send_group($urandom);
    send_item(CMD_TERM, 8'h00);
  endtask

  // Random byte streams with occasional terminates over several limits
  task automatic test_random_traffic();
    logic [COL_W-1:0] limits[RAND_PHASES];
    int unsigned      pause_at;
    int unsigned      pick;
    logic [7:0]       b;
    limits = '{10'd1, 10'd3, 10'd7, 10'd16, 10'd1023, 10'd0, 10'd0, 10'd128};
    limits[6] = 10'($urandom_range(1, 1023));
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_limit(limits[p]);
      tx_idle  = ($urandom_range(0, 3) != 0);
      rx_idle  = ($urandom_range(0, 3) != 0);
      pause_at = $urandom_range(5, PHASE_ITEMS - 5);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == pause_at) wait_results_done();
        pick = $urandom_range(0, 19);
        case (pick)
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom);
        endcase
        send_item((pick >= 17) ? CMD_TERM : CMD_DATA, b);
      end
      send_item(CMD_TERM, 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_DATA;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    tx_idle   = 1'b0;
    rx_idle   = 1'b0;
    col_limit = COLS_RESET;
    line_col  = '0;
    grp_word  = '0;
    grp_bytes = 0;
    mismatches    = 0;
    items_sent    = 0;
    chars_checked = 0;
    limit_writes  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_groups();
    test_limit_extremes();
    test_limit_lowered();
    test_quoting_paused();
    test_random_traffic();

    wait_results_done();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d items and %0d characters over %0d column limit settings,",
             items_sent, chars_checked, limit_writes);
    $display("including limits 0, 1 and 1023, a limit lowered below the open column and quoting paused mid-line.");
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("base85_string_literal_encoder regression: pass");
    end else begin
      $display("%0d mismatches, %0d characters never seen", mismatches,
               expected_chars.size());
      $display("base85_string_literal_encoder regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("%0t: timeout after %0d cycles", $realtime, LIMIT_CYCLES);
    $display("base85_string_literal_encoder regression: fail");
    $finish;
  end

endmodule
